@@ rtl/core/tcw_pkg.sv @@
package tcw_pkg;

	// Default screen geometry.
	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;

	// Attribute register value after reset.
	localparam logic [7:0] ATTR_RESET = 8'h07;

	// Character code that moves the cursor to a new line.
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;

	// Request codes.
	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

endpackage

@@ rtl/core/tcw_screen_ram.sv @@
module tcw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	// Each entry holds the attribute byte above the character byte.
	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/tcw_addr_unit.sv @@
module tcw_addr_unit #(
	parameter int SW = 12
) (
	input  logic [SW-1:0] opa,
	input  logic [SW-1:0] opb,
	input  logic [SW-1:0] limit,
	output logic [SW-1:0] sum,
	output logic          lt
);

	// One adder and one magnitude compare, shared by the multiply, column-add, cursor-advance and scroll steps.
	assign sum = opa + opb;
	assign lt  = (sum < limit);

endmodule

@@ rtl/core/text_console_writer.sv @@
// Text console writer: a screen of character and attribute cells with a cursor.
// A request transfers in at a rising edge where start is high and busy is low; it
// carries mode, char_code, read_row and read_col. Mode 0 prints char_code at the
// cursor with the attribute register (code 10 is a newline), mode 1 reads one cell,
// mode 2 clears the screen and homes the cursor. Each request gives one result,
// shown for exactly one cycle while done is high; the receiver cannot stall it.
// The attribute register is written through cfg_we and cfg_data; the user is to
// write it only while the block is idle, which the block itself does not enforce.
// With RW = clog2(ROWS), the row address is formed by RW shift-add steps on the
// shared adder before the column is added. A newline without scroll strobes in
// the next cycle. A scroll walks the screen store one cell per cycle and then
// flushes its last copy; a clear writes every cell. busy drops the cycle after
// the strobe, so the next request can transfer in from that cycle on.
// After reset the block runs a clearing pass over every cell with busy high;
// the cursor is at the home position and the attribute register holds 7.
module text_console_writer #(
	parameter int COLS = tcw_pkg::SCREEN_COLUMNS,
	parameter int ROWS = tcw_pkg::SCREEN_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [7:0] char_code,
	input  logic [4:0] read_row,
	input  logic [6:0] read_col,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	output logic       done,
	output logic [7:0] cell_char,
	output logic [7:0] cell_attr,
	output logic [6:0] cursor_col,
	output logic [4:0] cursor_row,
	output logic       scrolled
);

	localparam int CELLS = COLS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = AW + 1;
	localparam int CW    = $clog2(COLS);
	localparam int RW    = $clog2(ROWS);
	localparam int BW    = $clog2(RW + 1);

	// Sequencer states.
	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_MUL    = 4'd2;
	localparam logic [3:0] S_ADDC   = 4'd3;
	localparam logic [3:0] S_WRITE  = 4'd4;
	localparam logic [3:0] S_READ   = 4'd5;
	localparam logic [3:0] S_RWAIT  = 4'd6;
	localparam logic [3:0] S_SCROLL = 4'd7;
	localparam logic [3:0] S_SFLUSH = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0]    state_q;
	logic          is_write_q;   // the address being formed is for a print, not a read
	logic          clr_reply_q;  // a clear pass answers a request rather than reset
	logic [AW-1:0] addr_q;       // sweep position in the screen store
	logic [BW-1:0] cnt_q;        // remaining shift-add steps after the current one
	logic [SW-1:0] acc_q;        // cell address being formed
	logic [RW-1:0] row_op_q;
	logic [CW-1:0] col_op_q;
	logic [7:0]    chr_q;
	logic [7:0]    attr_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [7:0]    cell_char_q;
	logic [7:0]    cell_attr_q;
	logic          scr_q;

	// Scroll copy: the read issued in one cycle is written one row up in the next.
	logic          wr_s1;
	logic [AW-1:0] dst_s1;
	logic          zero_s1;

	logic [SW-1:0] opa;
	logic [SW-1:0] opb;
	logic [SW-1:0] limit;
	logic [SW-1:0] sum;
	logic          lt;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	logic          accept;
	logic          on_last_row;
	logic          read_in_range;
	logic [15:0]   col_wide;
	logic [15:0]   row_wide;

	assign accept        = start && (state_q == S_IDLE);
	assign on_last_row   = (cur_row_q == RW'(ROWS - 1));
	assign read_in_range = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLS));

	tcw_addr_unit #(
		.SW(SW)
	) u_unit (
		.opa  (opa),
		.opb  (opb),
		.limit(limit),
		.sum  (sum),
		.lt   (lt)
	);

	tcw_screen_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Operand selection for the shared adder and compare.
	always_comb begin
		opa   = '0;
		opb   = '0;
		limit = SW'(CELLS);
		case (state_q)
			S_MUL: begin
				// Horner step: double the partial address, add one row if the bit is set.
				opa = {acc_q[SW-2:0], 1'b0};
				opb = row_op_q[RW-1] ? SW'(COLS) : '0;
			end
			S_ADDC: begin
				opa = acc_q;
				opb = SW'(col_op_q);
			end
			S_WRITE: begin
				// Advance the cursor column and check it against the line length.
				opa   = SW'(cur_col_q);
				opb   = SW'(1);
				limit = SW'(COLS);
			end
			S_SCROLL: begin
				// Source cell is one row below the destination; past the end it reads as blank.
				opa = SW'(addr_q);
				opb = SW'(COLS);
			end
			default: begin
				opa = '0;
			end
		endcase
	end

	// Screen store ports.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = 16'd0;
		ram_re    = 1'b0;
		ram_raddr = acc_q[AW-1:0];
		if (wr_s1) begin
			ram_we    = 1'b1;
			ram_waddr = dst_s1;
			ram_wdata = zero_s1 ? 16'd0 : ram_rdata;
		end else if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = addr_q;
		end else if (state_q == S_WRITE) begin
			ram_we    = 1'b1;
			ram_waddr = acc_q[AW-1:0];
			ram_wdata = {attr_q, chr_q};
		end
		if (state_q == S_READ) begin
			ram_re = 1'b1;
		end else if (state_q == S_SCROLL) begin
			ram_re    = lt;
			ram_raddr = sum[AW-1:0];
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_data;
		end
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			cnt_q       <= '0;
			clr_reply_q <= 1'b0;
			is_write_q  <= 1'b0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			scr_q       <= 1'b0;
			wr_s1       <= 1'b0;
		end else begin
			wr_s1 <= (state_q == S_SCROLL);
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == AW'(CELLS - 1)) begin
						addr_q  <= '0;
						state_q <= clr_reply_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						scr_q <= 1'b0;
						cnt_q <= BW'(RW - 1);
						case (mode)
							tcw_pkg::MODE_PUT: begin
								is_write_q <= 1'b1;
								if (char_code == tcw_pkg::NEWLINE_CODE) begin
									cur_col_q <= '0;
									if (on_last_row) begin
										scr_q   <= 1'b1;
										addr_q  <= '0;
										state_q <= S_SCROLL;
									end else begin
										cur_row_q <= cur_row_q + 1'b1;
										state_q   <= S_DONE;
									end
								end else begin
									state_q <= S_MUL;
								end
							end
							tcw_pkg::MODE_READ: begin
								is_write_q <= 1'b0;
								state_q    <= read_in_range ? S_MUL : S_DONE;
							end
							tcw_pkg::MODE_CLEAR: begin
								cur_col_q   <= '0;
								cur_row_q   <= '0;
								clr_reply_q <= 1'b1;
								addr_q      <= '0;
								state_q     <= S_CLEAR;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_ADDC;
					end
				end
				S_ADDC: begin
					state_q <= is_write_q ? S_WRITE : S_READ;
				end
				S_WRITE: begin
					if (lt) begin
						cur_col_q <= sum[CW-1:0];
						state_q   <= S_DONE;
					end else begin
						// The line is full: wrap to the next line.
						cur_col_q <= '0;
						if (on_last_row) begin
							scr_q   <= 1'b1;
							addr_q  <= '0;
							state_q <= S_SCROLL;
						end else begin
							cur_row_q <= cur_row_q + 1'b1;
							state_q   <= S_DONE;
						end
					end
				end
				S_READ: begin
					state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					state_q <= S_DONE;
				end
				S_SCROLL: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == AW'(CELLS - 1)) begin
						addr_q  <= '0;
						state_q <= S_SFLUSH;
					end
				end
				S_SFLUSH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					clr_reply_q <= 1'b0;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					acc_q       <= '0;
					cell_char_q <= 8'd0;
					cell_attr_q <= 8'd0;
					chr_q       <= char_code;
					if (mode == tcw_pkg::MODE_READ) begin
						row_op_q <= RW'(read_row);
						col_op_q <= CW'(read_col);
					end else begin
						row_op_q <= cur_row_q;
						col_op_q <= cur_col_q;
					end
				end
			end
			S_MUL: begin
				acc_q    <= sum;
				row_op_q <= row_op_q << 1;
			end
			S_ADDC: begin
				acc_q <= sum;
			end
			S_RWAIT: begin
				cell_char_q <= ram_rdata[7:0];
				cell_attr_q <= ram_rdata[15:8];
			end
			S_SCROLL: begin
				dst_s1  <= addr_q;
				zero_s1 <= !lt;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign col_wide = 16'(cur_col_q);
	assign row_wide = 16'(cur_row_q);

	assign busy       = (state_q != S_IDLE);
	assign done       = (state_q == S_DONE);
	assign cell_char  = cell_char_q;
	assign cell_attr  = cell_attr_q;
	assign cursor_col = col_wide[6:0];
	assign cursor_row = row_wide[4:0];
	assign scrolled   = scr_q;

endmodule

@@ rtl/core/tcw_checker.sv @@
module tcw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic       done,
	input logic       scrolled,
	input logic [6:0] cursor_col,
	input logic [4:0] cursor_row
);

	// A result is only shown while the block still holds its request.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe without a request in progress");

	// An accepted request keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after a request transfer");

	// Each request gives a single one-cycle strobe.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A scroll always leaves the cursor at the start of a line.
	a_scroll_col: assert property (@(posedge clk) disable iff (!arst_n)
		(done && scrolled) |-> (cursor_col == 7'd0))
		else $error("scroll left the cursor off column zero");

	// A clear ends homed and unscrolled; this check can never fail.
	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == tcw_pkg::MODE_CLEAR)) |=>
			(!done || (cursor_col == 7'd0 && cursor_row == 5'd0 && !scrolled)))
		else $error("clear request did not home the cursor");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.mode      (mode),
	.done      (done),
	.scrolled  (scrolled),
	.cursor_col(cursor_col),
	.cursor_row(cursor_row)
);
